### hw/rtl/assert_macros.svh
// Assertion macros for the RTL that checks itself (the scheduler top).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, not checked while rst is high.
`define SJF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define SJF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sjf_pkg.sv
// ----------------------------------------------------------------------------
// sjf_pkg
// Types and constants shared by the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
package sjf_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);

  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic        func;
    logic [7:0]  job_id;
    logic [15:0] arrival;
    logic [15:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [15:0] now;
    logic        busy_res;
    logic [7:0]  running_job;
    logic        dispatched;
    logic        completed;
    logic        all_done;
    logic [31:0] total_wait;
    logic        rejected;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             scan;
    logic [IDX_W-1:0] idx;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

endpackage

### hw/rtl/sjf_in_if.sv
// ----------------------------------------------------------------------------
// sjf_in_if
// Input channel of the scheduler: valid, ready and one job or tick word.
// ----------------------------------------------------------------------------
interface sjf_in_if;
  logic              valid;
  logic              ready;
  sjf_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/sjf_out_if.sv
// ----------------------------------------------------------------------------
// sjf_out_if
// Output channel of the scheduler: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface sjf_out_if;
  logic               valid;
  logic               ready;
  sjf_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/sjf_ctrl.sv
// ----------------------------------------------------------------------------
// sjf_ctrl
// Controller: accepts a word, steps the table scan and finishes the item.
// ----------------------------------------------------------------------------
module sjf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_func,
  output logic             in_ready,
  input  sjf_pkg::status_t status,
  output sjf_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [sjf_pkg::IDX_W-1:0] idx;
  logic [sjf_pkg::IDX_W-1:0] idx_next;

  always_comb begin
    state_next = state;
    idx_next = idx;
    in_ready = 1'b0;
    cmd = '0;
    cmd.idx = idx;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          idx_next = '0;
          state_next = (in_func == sjf_pkg::FUNC_TICK) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == sjf_pkg::IDX_W'(sjf_pkg::TABLE_DEPTH - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
    end
  end

endmodule

### hw/rtl/sjf_dp.sv
// ----------------------------------------------------------------------------
// sjf_dp
// Datapath: job table, processor state, wait total and the result register.
// ----------------------------------------------------------------------------
module sjf_dp (
  input  logic               clk,
  input  logic               rst,
  input  sjf_pkg::cmd_t      cmd,
  output sjf_pkg::status_t   status,
  input  sjf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sjf_pkg::out_item_t out_item
);

  localparam int D = sjf_pkg::TABLE_DEPTH;
  localparam int W = sjf_pkg::IDX_W;

  logic [D-1:0] occ;
  logic [D-1:0] rdy;
  logic [7:0]   tab_id [D];
  logic [15:0]  tab_arr [D];
  logic [15:0]  tab_burst [D];
  logic [7:0]   tab_seq [D];

  sjf_pkg::in_item_t it;
  logic [15:0] time_count;
  logic [7:0]  submit_seq;
  logic        busy;
  logic [7:0]  cpu_job;
  logic [15:0] cpu_arr;
  logic [15:0] cpu_start;
  logic [15:0] cpu_burst;
  logic [31:0] wait_sum;
  logic        cflag;

  logic         found;
  logic [W-1:0] best_idx;
  logic [7:0]   best_id;
  logic [15:0]  best_arr;
  logic [15:0]  best_burst;
  logic [7:0]   best_seq;

  logic         promote;
  logic         take;
  logic         done_now;
  logic [32:0]  sum;
  logic [W-1:0] free_idx;
  logic         any_free;
  logic         do_dispatch;
  logic         do_store;
  logic         busy_after;
  logic [7:0]   job_after;
  logic [D-1:0] occ_after;

  assign promote = occ[cmd.idx] && !rdy[cmd.idx] && (tab_arr[cmd.idx] == time_count);
  assign take = !busy && (rdy[cmd.idx] || promote) && (!found
      || (tab_burst[cmd.idx] < best_burst)
      || (tab_burst[cmd.idx] == best_burst && tab_arr[cmd.idx] < best_arr)
      || (tab_burst[cmd.idx] == best_burst && tab_arr[cmd.idx] == best_arr
          && tab_seq[cmd.idx] < best_seq));
  assign done_now = busy && (16'(cpu_start + cpu_burst) == time_count);
  assign sum = {1'b0, wait_sum} + {17'd0, 16'(cpu_start - cpu_arr)};

  always_comb begin
    free_idx = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (!occ[i]) begin
        free_idx = W'(i);
      end
    end
  end

  assign any_free = ~&occ;
  assign do_dispatch = (it.func == sjf_pkg::FUNC_TICK) && found;
  assign do_store = (it.func == sjf_pkg::FUNC_SUBMIT) && any_free;
  assign busy_after = busy || do_dispatch;
  assign job_after = do_dispatch ? best_id : cpu_job;

  always_comb begin
    occ_after = occ;
    if (do_dispatch) begin
      occ_after[best_idx] = 1'b0;
    end
    if (do_store) begin
      occ_after[free_idx] = 1'b1;
    end
  end

  assign status.slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it <= in_item;
    end
    if (cmd.scan && take) begin
      best_idx <= cmd.idx;
      best_id <= tab_id[cmd.idx];
      best_arr <= tab_arr[cmd.idx];
      best_burst <= tab_burst[cmd.idx];
      best_seq <= tab_seq[cmd.idx];
    end
    if (cmd.finish && do_dispatch) begin
      cpu_job <= best_id;
      cpu_arr <= best_arr;
      cpu_burst <= best_burst;
      cpu_start <= time_count;
    end
    if (cmd.finish && do_store) begin
      tab_id[free_idx] <= it.job_id;
      tab_arr[free_idx] <= it.arrival;
      tab_burst[free_idx] <= it.burst;
      tab_seq[free_idx] <= submit_seq;
    end
    if (cmd.finish) begin
      out_item.now <= time_count;
      out_item.busy_res <= busy_after;
      out_item.running_job <= busy_after ? job_after : 8'd0;
      out_item.dispatched <= do_dispatch;
      out_item.completed <= cflag;
      out_item.all_done <= !busy_after && !(|occ_after);
      out_item.total_wait <= wait_sum;
      out_item.rejected <= (it.func == sjf_pkg::FUNC_SUBMIT) && !any_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      rdy <= '0;
      time_count <= '0;
      submit_seq <= '0;
      busy <= 1'b0;
      wait_sum <= '0;
      cflag <= 1'b0;
      found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        found <= 1'b0;
        cflag <= 1'b0;
        if (in_item.func == sjf_pkg::FUNC_TICK && done_now) begin
          cflag <= 1'b1;
          busy <= 1'b0;
          wait_sum <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
      if (cmd.scan) begin
        if (promote) begin
          rdy[cmd.idx] <= 1'b1;
        end
        if (take) begin
          found <= 1'b1;
        end
      end
      if (cmd.finish) begin
        occ <= occ_after;
        if (do_dispatch) begin
          busy <= 1'b1;
          rdy[best_idx] <= 1'b0;
        end
        if (do_store) begin
          rdy[free_idx] <= 1'b0;
          submit_seq <= submit_seq + 8'd1;
        end
        if (it.func == sjf_pkg::FUNC_TICK) begin
          time_count <= time_count + 16'd1;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/sjf_nonpreemptive_scheduler.sv
// A submit word goes from acceptance straight to the FINISH state; a tick word first passes the SCAN state,
// which reads all TABLE_DEPTH table entries one entry a cycle. FINISH loads the result register once it is free.
// Throughput: one word at a time; a new word is taken the cycle after the result is loaded.
// The result register lets the next word in while a result waits to be taken.
// Reset (rst, synchronous) empties the table and clears time, processor state and wait total.
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler
// Non-preemptive shortest-job-first scheduler over a table of jobs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sjf_nonpreemptive_scheduler (
  input logic     clk,
  input logic     rst,
  sjf_in_if.sink  jobs,
  sjf_out_if.source results
);

  sjf_pkg::cmd_t    cmd;
  sjf_pkg::status_t status;

  sjf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (jobs.valid),
    .in_func  (jobs.payload.func),
    .in_ready (jobs.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sjf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (jobs.payload),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_item  (results.payload)
  );

  `SJF_ASSERT(a_dispatch_busy, results.valid && results.payload.dispatched |-> results.payload.busy_res, "dispatch without busy processor")
  `SJF_ASSERT(a_done_idle, results.valid && results.payload.all_done |-> !results.payload.busy_res, "all done while busy")
  `SJF_ASSERT(a_no_overwrite, results.valid && !results.ready |-> !cmd.finish, "result overwritten")
  `SJF_ASSERT_ALWAYS(a_scan_not_ready, !(cmd.scan && jobs.ready), "input ready during scan")

endmodule
